// ===== rtl/core/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// Shared widths, constants and status codes for the fitness proportional
// selector.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int CUM_W     = 22;
    localparam int PROB_W    = 16;
    localparam int LAMBDA_W  = 7;
    localparam int PTR_W     = 6;
    localparam int OUT_IDX_W = 6;
    localparam int STATUS_W  = 2;
    localparam int PROD_W    = CUM_W + LAMBDA_W;

    localparam logic [CUM_W-1:0]    ONE_Q16   = CUM_W'(65536);
    localparam logic [CUM_W-1:0]    TOL_LOW   = CUM_W'(64881);
    localparam logic [CUM_W-1:0]    TOL_HIGH  = CUM_W'(66191);
    localparam logic [CUM_W-1:0]    TOTAL_MAX = {CUM_W{1'b1}};
    localparam logic [LAMBDA_W-1:0] MAX_DRAWS = LAMBDA_W'(64);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_TOL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_TABLE = 2'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    localparam logic MODE_ROULETTE = 1'b0;
    localparam logic MODE_SUS      = 1'b1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_DRAWS = 1'b1;

endpackage

// ===== rtl/core/fps_cum_mem.sv =====
// ----------------------------------------------------------------------------
// fps_cum_mem
// Cumulative probability table: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fps_cum_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [fps_pkg::CUM_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic [fps_pkg::CUM_W-1:0] rdata
);
    import fps_pkg::*;

    logic [CUM_W-1:0] mem [DEPTH];
    logic [CUM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fitness_proportional_selector_unit.sv =====
// ----------------------------------------------------------------------------
// fitness_proportional_selector_unit
// Roulette wheel and stochastic universal sampling over a cumulative
// probability table held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid in_stall kind weight random_value | in
//           | last_weight                               |
//  out      | out_valid out_stall index last status     | out
//  cfg      | psel penable pwrite paddr pwdata prdata   | in/out
//           | pready (mode at 0x0, draws_per_round 0x4) |
//
// a load item is one table write
// a roulette draw is a binary search: each step is one memory read plus a
// compare; a draw with no table goes straight to its result
// a sampling round walks the table: each table entry is one read and a
// compare, each pointer that lands on it one result
// reset needs no clearing pass; a stalled output holds the walk in place
module fitness_proportional_selector_unit #(
    parameter int MAX_POPULATION = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [fps_pkg::PROB_W-1:0]    weight,
    input  logic [fps_pkg::PROB_W-1:0]    random_value,
    input  logic                          last_weight,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fps_pkg::OUT_IDX_W-1:0] index,
    output logic                          last,
    output logic [fps_pkg::STATUS_W-1:0]  status,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import fps_pkg::*;

    localparam int IW = $clog2(MAX_POPULATION);
    localparam int CW = $clog2(MAX_POPULATION + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POPULATION);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SRCH_RD  = 3'd1;
    localparam logic [2:0] S_SRCH_CMP = 3'd2;
    localparam logic [2:0] S_EMIT1    = 3'd3;
    localparam logic [2:0] S_SUS_RD   = 3'd4;
    localparam logic [2:0] S_SUS_CMP  = 3'd5;

    // configuration
    logic                mode_reg;
    logic [LAMBDA_W-1:0] draws_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ROULETTE;
            draws_reg <= LAMBDA_W'(1);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_DRAWS: draws_reg <= pwdata[LAMBDA_W-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MODE:  prdata = {31'd0, mode_reg};
            REG_DRAWS: prdata = {{(32-LAMBDA_W){1'b0}}, draws_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // state registers
    logic [2:0]          state_reg, state_next;
    logic [CUM_W-1:0]    total_reg, total_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ready_reg, ready_next;
    logic                oor_reg, oor_next;
    logic [IW-1:0]       lo_reg, lo_next;
    logic [IW-1:0]       hi_reg, hi_next;
    logic [PTR_W-1:0]    j_reg, j_next;
    logic [LAMBDA_W-1:0] lam_reg, lam_next;
    logic [PROB_W-1:0]   rnd_reg, rnd_next;
    logic [STATUS_W-1:0] st_reg, st_next;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0] index_reg, index_next;
    logic                 last_reg, last_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    // memory ports
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [CUM_W-1:0] mem_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [CUM_W-1:0] mem_rdata;

    fps_cum_mem #(
        .DEPTH (MAX_POPULATION),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic              accept;
    logic              out_free;
    logic [IW:0]       mid_sum;
    logic [IW-1:0]     mid;
    logic [CW-1:0]     cnt_base;
    logic [CUM_W-1:0]  tot_base;
    logic [CUM_W:0]    sum_wide;
    logic [CUM_W-1:0]  sum_sat;
    logic [CW-1:0]     cnt_inc;
    logic              load_final;
    logic [LAMBDA_W-1:0] lam_eff;
    logic [PROD_W-1:0] bound;
    logic [PROD_W-1:0] ptr_pos;
    logic              at_end;
    logic              sus_hit;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign index     = index_reg;
    assign last      = last_reg;
    assign status    = status_reg;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[IW:1];

    // load path: a load after a finished table starts a new population
    assign cnt_base   = ready_reg ? '0 : count_reg;
    assign tot_base   = ready_reg ? '0 : total_reg;
    assign sum_wide   = {1'b0, tot_base} + {{(CUM_W+1-PROB_W){1'b0}}, weight};
    assign sum_sat    = sum_wide[CUM_W] ? TOTAL_MAX : sum_wide[CUM_W-1:0];
    assign cnt_inc    = cnt_base + CW'(1);
    assign load_final = last_weight || (cnt_inc >= MAX_CNT);

    always_comb
    begin
        if (draws_reg == '0)
            lam_eff = LAMBDA_W'(1);
        else if (draws_reg > MAX_DRAWS)
            lam_eff = MAX_DRAWS;
        else
            lam_eff = draws_reg;
    end

    // pointer j sits at f + j*1.0, compared against cum*lambda
    assign bound   = {{LAMBDA_W{1'b0}}, mem_rdata} * {{CUM_W{1'b0}}, lam_reg};
    assign ptr_pos = PROD_W'({j_reg, rnd_reg});
    assign at_end  = (lo_reg == hi_reg);
    assign sus_hit = (ptr_pos <= bound) || at_end;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_base[IW-1:0];
        mem_wdata = load_final ? ONE_Q16 : sum_sat;
        mem_raddr = (state_reg == S_SRCH_RD) ? mid : lo_reg;

        state_next     = state_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        oor_next       = oor_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        lam_next       = lam_reg;
        rnd_next       = rnd_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        last_next      = last_reg;
        status_next    = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        total_next = tot_base;
                        count_next = cnt_base;
                        ready_next = 1'b0;
                        oor_next   = ready_reg ? 1'b0 : oor_reg;
                        if (cnt_base < MAX_CNT)
                        begin
                            mem_we     = 1'b1;
                            total_next = sum_sat;
                            count_next = cnt_inc;
                            if (load_final)
                            begin
                                ready_next = 1'b1;
                                oor_next   = (sum_sat < TOL_LOW) || (sum_sat > TOL_HIGH);
                            end
                        end
                    end
                    else
                    begin
                        rnd_next = random_value;
                        lam_next = lam_eff;
                        j_next   = '0;
                        lo_next  = '0;
                        hi_next  = IW'(count_reg - CW'(1));
                        st_next  = oor_reg ? ST_OUT_TOL : ST_OK;
                        if (!ready_reg || count_reg == '0)
                        begin
                            st_next    = ST_NO_TABLE;
                            hi_next    = '0;
                            state_next = S_EMIT1;
                        end
                        else if (mode_reg == MODE_ROULETTE)
                        begin
                            state_next = S_SRCH_RD;
                        end
                        else
                        begin
                            state_next = S_SUS_RD;
                        end
                    end
                end
            end

            S_SRCH_RD:
            begin
                state_next = at_end ? S_EMIT1 : S_SRCH_CMP;
            end

            S_SRCH_CMP:
            begin
                // memory holds cum[mid]; mid never reaches the forced final entry
                if (mem_rdata >= {{(CUM_W-PROB_W){1'b0}}, rnd_reg})
                    hi_next = mid;
                else
                    lo_next = mid + IW'(1);
                state_next = S_SRCH_RD;
            end

            S_EMIT1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    index_next     = OUT_IDX_W'(lo_reg);
                    last_next      = 1'b1;
                    status_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end

            S_SUS_RD:
            begin
                state_next = S_SUS_CMP;
            end

            S_SUS_CMP:
            begin
                if (sus_hit)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        index_next     = OUT_IDX_W'(lo_reg);
                        last_next      = ({1'b0, j_reg} == lam_reg - LAMBDA_W'(1));
                        status_next    = st_reg;
                        if ({1'b0, j_reg} == lam_reg - LAMBDA_W'(1))
                            state_next = S_IDLE;
                        else
                            j_next = j_reg + PTR_W'(1);
                    end
                end
                else
                begin
                    lo_next    = lo_reg + IW'(1);
                    state_next = S_SUS_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        j_reg      <= j_next;
        lam_reg    <= lam_next;
        rnd_reg    <= rnd_next;
        st_reg     <= st_next;
        index_reg  <= index_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

endmodule
